@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while reset is released.
`define TTT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ttt check failed");

// Check a property on every edge, reset included.
`define TTT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ttt check failed");

`endif

@@ sv/ttt_pkg.sv @@
// Package of the thermistor table temperature block: constants, codes, state type.
// No dependencies.
package ttt_pkg;

    localparam int TABLE_SIZE_DEF = 131;

    localparam int SERIES_W = 20;
    localparam int REF_W    = 13;
    localparam int FS_W     = 16;
    localparam int OFF_W    = 8;
    localparam int CFG_W    = 20;
    localparam int CFG_IW   = 2;
    localparam int ENTRY_W  = 20;
    localparam int SAMPLE_W = 16;
    localparam int EIDX_W   = 8;
    localparam int RES_W    = 32;
    localparam int DEG_W    = 9;
    localparam int TEN_W    = 13;

    // Shared divider: dividend and divisor widths, steps per division
    localparam int DIV_W     = 33;
    localparam int DVS_W     = 20;
    localparam int DIV_STEPS = 33;
    localparam int CNT_W     = 6;

    localparam logic [SERIES_W-1:0] SERIES_RST = 20'd100000;
    localparam logic [REF_W-1:0]    REF_RST    = 13'd3300;
    localparam logic [FS_W-1:0]     FS_RST     = 16'd4095;
    localparam logic [OFF_W-1:0]    OFF_RST    = 8'd20;

    localparam logic [CFG_IW-1:0] CFG_SERIES = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_REF    = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_FS     = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_OFF    = 2'd3;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_COLDER = 2'd1;
    localparam logic [1:0] ST_HOTTER = 2'd2;
    localparam logic [1:0] ST_OPEN   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV1,
        S_CHK1,
        S_DIV2,
        S_RES,
        S_SRD,
        S_SCMP,
        S_PWT,
        S_CWT,
        S_IDIV,
        S_IFIN,
        S_DONE
    } t_state;

endpackage

@@ sv/ttt_in_if.sv @@
// Input channel of the thermistor block: handshake plus load/convert payload.
// Depends on ttt_pkg.
interface ttt_in_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [ttt_pkg::EIDX_W-1:0]    entry_index;
    logic [ttt_pkg::ENTRY_W-1:0]   entry_value;
    logic [ttt_pkg::SAMPLE_W-1:0]  adc_sample;

    modport source (output valid, req_type, entry_index, entry_value, adc_sample,
                    input ready);
    modport sink   (input valid, req_type, entry_index, entry_value, adc_sample,
                    output ready);
endinterface

@@ sv/ttt_out_if.sv @@
// Result channel of the thermistor block: handshake plus temperature payload.
// Depends on ttt_pkg.
interface ttt_out_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [ttt_pkg::RES_W-1:0]         resistance_ohms;
    logic signed [ttt_pkg::DEG_W-1:0]  temp_degrees;
    logic signed [ttt_pkg::TEN_W-1:0]  temp_tenths;
    logic [ttt_pkg::EIDX_W-1:0]        found_index;

    modport source (output valid, status, resistance_ohms, temp_degrees, temp_tenths,
                    found_index, input ready);
    modport sink   (input valid, status, resistance_ohms, temp_degrees, temp_tenths,
                    found_index, output ready);
endinterface

@@ sv/ttt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ttt_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 131
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ sv/thermistor_table_temperature.sv @@
// Thermistor table temperature block: table RAM, shared serial divider, bisection.
// Depends on ttt_pkg, ttt_in_if, ttt_out_if and ttt_ram.
//
//  channel   | dir | transfer when         | payload
//  ----------+-----+-----------------------+-----------------------------------------
//  i_in      | in  | valid & ready         | req_type, entry_index, entry_value, adc_sample
//  o_out     | out | valid & ready         | status, resistance_ohms, temp_degrees,
//            |     |                       | temp_tenths, found_index
//  i_cfg_*   | in  | i_cfg_we              | i_cfg_index, i_cfg_data
//
// A load writes the table entry when taken, if entry_index is below TABLE_SIZE. A convert
// runs the shared radix-2 divider up to three times, with a binary search of up to
// ceil(log2(TABLE_SIZE+1)) probes between the second and the third run.
// Input is taken only in idle; a finished result waits in the output register and
// the next item may enter meanwhile. Reset clears the state, the configuration registers
// and the output valid flag; table contents stay undefined until loaded.
module thermistor_table_temperature #(
    parameter int TABLE_SIZE = ttt_pkg::TABLE_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ttt_in_if.sink                     i_in,
    ttt_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [ttt_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [ttt_pkg::CFG_W-1:0]  i_cfg_data
);
    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam int DIV_W = ttt_pkg::DIV_W;
    localparam int DVS_W = ttt_pkg::DVS_W;
    localparam int DEG_W = ttt_pkg::DEG_W;

    // Configuration registers
    logic [ttt_pkg::SERIES_W-1:0] r_series;
    logic [ttt_pkg::REF_W-1:0]    r_ref;
    logic [ttt_pkg::FS_W-1:0]     r_fs;
    logic [ttt_pkg::OFF_W-1:0]    r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series <= ttt_pkg::SERIES_RST;
            r_ref    <= ttt_pkg::REF_RST;
            r_fs     <= ttt_pkg::FS_RST;
            r_off    <= ttt_pkg::OFF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ttt_pkg::CFG_SERIES: r_series <= i_cfg_data[ttt_pkg::SERIES_W-1:0];
                ttt_pkg::CFG_REF:    r_ref    <= i_cfg_data[ttt_pkg::REF_W-1:0];
                ttt_pkg::CFG_FS:     r_fs     <= i_cfg_data[ttt_pkg::FS_W-1:0];
                ttt_pkg::CFG_OFF:    r_off    <= i_cfg_data[ttt_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    ttt_pkg::t_state r_state, n_state;

    logic               in_xfer;
    logic               out_free;
    logic               div_last;
    logic               load_ok;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [ttt_pkg::ENTRY_W-1:0] ram_rdata;

    // Divider registers
    logic [DIV_W-1:0]   r_dvd;
    logic [DVS_W-1:0]   r_dvs;
    logic [DVS_W:0]     r_rem;
    logic [DIV_W-1:0]   r_quo;
    logic [ttt_pkg::CNT_W-1:0] r_cnt;

    // Search and result registers
    logic [CW-1:0]      r_lo, r_hi;
    logic [ttt_pkg::RES_W-1:0]   r_res;
    logic [ttt_pkg::ENTRY_W-1:0] r_prev;
    logic [1:0]         r_st;
    logic [DEG_W-1:0]   r_deg;
    logic [ttt_pkg::TEN_W-1:0] r_ten;
    logic [ttt_pkg::EIDX_W-1:0] r_idx;

    // Output register
    logic               r_ovalid;
    logic [1:0]         r_ost;
    logic [ttt_pkg::RES_W-1:0] r_ores;
    logic [DEG_W-1:0]   r_odeg;
    logic [ttt_pkg::TEN_W-1:0] r_oten;
    logic [ttt_pkg::EIDX_W-1:0] r_oidx;

    assign in_xfer  = i_in.valid & i_in.ready;
    assign out_free = !r_ovalid | o_out.ready;
    assign div_last = (r_cnt == '0);
    assign load_ok  = ({1'b0, i_in.entry_index} < 9'(TABLE_SIZE));

    // Divider step: shift in one dividend bit, subtract when it fits
    logic [DVS_W:0]   rem_sh, rem_nx;
    logic             q_bit;
    always_comb begin
        rem_sh = {r_rem[DVS_W-1:0], r_dvd[DIV_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dvs});
        rem_nx = q_bit ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    end

    // Search midpoint and helpers
    logic [CW:0]      mid_sum;
    logic [CW-1:0]    mid;
    logic             srch_go, lo_zero, lo_end;
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign srch_go = (r_lo < r_hi);
    assign lo_zero = (r_lo == '0);
    assign lo_end  = (r_lo == CW'(TABLE_SIZE));

    // Degree arithmetic on the final index
    logic [CW-1:0]        lo_m1;
    logic [DEG_W-1:0]     deg_lo, deg_pm1, deg_top;
    logic signed [13:0]   ten_lo, ten_top, ten_base;
    assign lo_m1   = r_lo - 1'b1;
    assign deg_lo  = DEG_W'(r_lo) - {1'b0, r_off};
    assign deg_pm1 = DEG_W'(lo_m1) - {1'b0, r_off};
    assign deg_top = DEG_W'(TABLE_SIZE - 1) - {1'b0, r_off};

    function automatic logic signed [13:0] times10(input logic [8:0] d);
        logic signed [13:0] e;
        e = 14'(signed'(d));
        return (e <<< 3) + (e <<< 1);
    endfunction

    assign ten_lo   = times10(deg_lo);
    assign ten_top  = times10(deg_top);
    assign ten_base = times10(deg_pm1);

    // Operand products, registered into the divider
    logic [28:0]              prod1;
    logic [DIV_W-1:0]         prod2;
    logic [ttt_pkg::ENTRY_W-1:0] diff_pr, diff_pc;
    logic [23:0]              prod3;
    assign prod1   = 29'(r_ref) * 29'(i_in.adc_sample);
    assign prod2   = DIV_W'(r_series) * DIV_W'(r_quo[ttt_pkg::REF_W-1:0]);
    assign diff_pr = r_prev - r_res[ttt_pkg::ENTRY_W-1:0];
    assign diff_pc = r_prev - ram_rdata;
    assign prod3   = (24'(diff_pr) << 3) + (24'(diff_pr) << 1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ttt_pkg::S_IDLE: begin
                if (in_xfer && i_in.req_type == ttt_pkg::REQ_CONVERT) begin
                    n_state = (r_fs == '0) ? ttt_pkg::S_DONE : ttt_pkg::S_DIV1;
                end
            end
            ttt_pkg::S_DIV1: if (div_last) n_state = ttt_pkg::S_CHK1;
            ttt_pkg::S_CHK1: begin
                n_state = (r_quo >= DIV_W'(r_ref)) ? ttt_pkg::S_DONE : ttt_pkg::S_DIV2;
            end
            ttt_pkg::S_DIV2: if (div_last) n_state = ttt_pkg::S_RES;
            ttt_pkg::S_RES:  n_state = ttt_pkg::S_SRD;
            ttt_pkg::S_SRD: begin
                if (srch_go)     n_state = ttt_pkg::S_SCMP;
                else if (lo_end) n_state = ttt_pkg::S_DONE;
                else             n_state = ttt_pkg::S_PWT;
            end
            ttt_pkg::S_SCMP: n_state = ttt_pkg::S_SRD;
            ttt_pkg::S_PWT:  n_state = lo_zero ? ttt_pkg::S_DONE : ttt_pkg::S_CWT;
            ttt_pkg::S_CWT:  n_state = ttt_pkg::S_IDIV;
            ttt_pkg::S_IDIV: if (div_last) n_state = ttt_pkg::S_IFIN;
            ttt_pkg::S_IFIN: n_state = ttt_pkg::S_DONE;
            ttt_pkg::S_DONE: if (out_free) n_state = ttt_pkg::S_IDLE;
            default:         n_state = ttt_pkg::S_IDLE;
        endcase
    end

    // Control outputs: ready, table write, read address
    always_comb begin
        i_in.ready = (r_state == ttt_pkg::S_IDLE);
        ram_we     = in_xfer && (i_in.req_type == ttt_pkg::REQ_LOAD) && load_ok;
        ram_raddr  = mid[AW-1:0];
        case (r_state)
            ttt_pkg::S_SRD: begin
                if (srch_go)      ram_raddr = mid[AW-1:0];
                else if (lo_zero) ram_raddr = '0;
                else              ram_raddr = lo_m1[AW-1:0];
            end
            ttt_pkg::S_PWT: ram_raddr = r_lo[AW-1:0];
            default:        ram_raddr = mid[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ttt_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    ttt_ram #(
        .WIDTH (ttt_pkg::ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in.entry_index[AW-1:0]),
        .i_wdata (i_in.entry_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Datapath: divider, search bounds, pending result
    always_ff @(posedge i_clk) begin
        case (r_state)
            ttt_pkg::S_IDLE: begin
                r_st  <= ttt_pkg::ST_OPEN;
                r_res <= '1;
                r_deg <= '0;
                r_ten <= '0;
                r_idx <= '0;
                r_dvd <= DIV_W'(prod1);
                r_dvs <= DVS_W'(r_fs);
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= ttt_pkg::CNT_W'(ttt_pkg::DIV_STEPS - 1);
            end
            ttt_pkg::S_DIV1, ttt_pkg::S_DIV2, ttt_pkg::S_IDIV: begin
                r_rem <= rem_nx;
                r_dvd <= r_dvd << 1;
                r_quo <= {r_quo[DIV_W-2:0], q_bit};
                r_cnt <= r_cnt - 1'b1;
            end
            ttt_pkg::S_CHK1: begin
                r_dvd <= prod2;
                r_dvs <= DVS_W'(r_ref - r_quo[ttt_pkg::REF_W-1:0]);
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= ttt_pkg::CNT_W'(ttt_pkg::DIV_STEPS - 1);
            end
            ttt_pkg::S_RES: begin
                r_res <= r_quo[DIV_W-1] ? '1 : r_quo[ttt_pkg::RES_W-1:0];
                r_lo  <= '0;
                r_hi  <= CW'(TABLE_SIZE);
            end
            ttt_pkg::S_SRD: begin
                if (!srch_go && lo_end) begin
                    r_st  <= ttt_pkg::ST_HOTTER;
                    r_deg <= deg_top;
                    r_ten <= ttt_pkg::TEN_W'(ten_top);
                    r_idx <= ttt_pkg::EIDX_W'(TABLE_SIZE - 1);
                end
            end
            ttt_pkg::S_SCMP: begin
                if ({12'b0, ram_rdata} <= r_res) r_hi <= mid;
                else                             r_lo <= mid + 1'b1;
            end
            ttt_pkg::S_PWT: begin
                r_prev <= ram_rdata;
                r_deg  <= deg_lo;
                r_idx  <= ttt_pkg::EIDX_W'(r_lo);
                if (lo_zero) begin
                    r_st  <= ({12'b0, ram_rdata} == r_res) ? ttt_pkg::ST_OK
                                                           : ttt_pkg::ST_COLDER;
                    r_ten <= ttt_pkg::TEN_W'(ten_lo);
                end
            end
            ttt_pkg::S_CWT: begin
                r_dvd <= DIV_W'(prod3);
                r_dvs <= diff_pc;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= ttt_pkg::CNT_W'(ttt_pkg::DIV_STEPS - 1);
            end
            ttt_pkg::S_IFIN: begin
                r_st  <= ttt_pkg::ST_OK;
                r_ten <= ttt_pkg::TEN_W'(ten_base + 14'(r_quo[3:0]));
            end
            default: ;
        endcase
    end

    // Output register: load on finish, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ttt_pkg::S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ttt_pkg::S_DONE && out_free) begin
            r_ost  <= r_st;
            r_ores <= r_res;
            r_odeg <= r_deg;
            r_oten <= r_ten;
            r_oidx <= r_idx;
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.status          = r_ost;
    assign o_out.resistance_ohms = r_ores;
    assign o_out.temp_degrees    = signed'(r_odeg);
    assign o_out.temp_tenths     = signed'(r_oten);
    assign o_out.found_index     = r_oidx;
endmodule

@@ sv/ttt_checker.sv @@
// Port-level checks of the thermistor block, bound to the top level.
// Depends on ttt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ttt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [1:0]                        i_status,
    input logic [ttt_pkg::RES_W-1:0]         i_res,
    input logic signed [ttt_pkg::DEG_W-1:0]  i_deg,
    input logic signed [ttt_pkg::TEN_W-1:0]  i_ten,
    input logic [ttt_pkg::EIDX_W-1:0]        i_idx
);
    // A stalled result stays valid with resistance and tenths held
    `TTT_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_res) && $stable(i_ten)))
    // No result right after reset
    `TTT_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid)
    // Open input gives saturated resistance and zero temperature
    `TTT_ASSERT(a_open_fields, i_clk, i_rst_n, (i_out_valid && i_status == ttt_pkg::ST_OPEN) |-> (i_res == '1 && i_deg == '0 && i_ten == '0 && i_idx == '0))
    // Colder than table clamps to the first entry
    `TTT_ASSERT(a_cold_clamp, i_clk, i_rst_n, (i_out_valid && i_status == ttt_pkg::ST_COLDER) |-> (i_idx == '0))
endmodule

bind thermistor_table_temperature ttt_checker u_ttt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_res       (o_out.resistance_ohms),
    .i_deg       (o_out.temp_degrees),
    .i_ten       (o_out.temp_tenths),
    .i_idx       (o_out.found_index)
);

@@ tb/sv/thermistor_table_temperature_test.sv @@
// Self-checking testbench of thermistor_table_temperature: loads resistance tables,
// converts ADC samples under several register settings and checks every result.
// Depends on ttt_pkg, ttt_in_if, ttt_out_if and the block itself.
`timescale 1ns / 1ps

module thermistor_table_temperature_test;

    localparam int TS = ttt_pkg::TABLE_SIZE_DEF;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [1:0]                       status;
        logic [ttt_pkg::RES_W-1:0]        res;
        logic signed [ttt_pkg::DEG_W-1:0] deg;
        logic signed [ttt_pkg::TEN_W-1:0] tenths;
        logic [ttt_pkg::EIDX_W-1:0]       idx;
    } t_temp_result;

    // Table copy, register copy and queue of pending temperature readings
    class thermistor_scoreboard;
        logic [ttt_pkg::ENTRY_W-1:0]  tbl [TS];
        logic [ttt_pkg::SERIES_W-1:0] series;
        logic [ttt_pkg::REF_W-1:0]    vref;
        logic [ttt_pkg::FS_W-1:0]     full_scale;
        logic [ttt_pkg::OFF_W-1:0]    offset;
        t_temp_result                 pending [$];
        int                           errors;

        function new();
            series     = ttt_pkg::SERIES_RST;
            vref       = ttt_pkg::REF_RST;
            full_scale = ttt_pkg::FS_RST;
            offset     = ttt_pkg::OFF_RST;
            errors     = 0;
            foreach (tbl[i]) tbl[i] = '0;
        endfunction

        function void set_reg(logic [ttt_pkg::CFG_IW-1:0] index,
                              logic [ttt_pkg::CFG_W-1:0] data);
            case (index)
                ttt_pkg::CFG_SERIES: series     = data[ttt_pkg::SERIES_W-1:0];
                ttt_pkg::CFG_REF:    vref       = data[ttt_pkg::REF_W-1:0];
                ttt_pkg::CFG_FS:     full_scale = data[ttt_pkg::FS_W-1:0];
                ttt_pkg::CFG_OFF:    offset     = data[ttt_pkg::OFF_W-1:0];
                default: ;
            endcase
        endfunction

        // Divider resistance for one sample; saturated to 32 bits
        function logic [ttt_pkg::RES_W-1:0] ohms_for(logic [ttt_pkg::SAMPLE_W-1:0] sample);
            logic [63:0] mv;
            logic [63:0] r64;
            mv  = (64'(vref) * 64'(sample)) / 64'(full_scale);
            r64 = (64'(series) * mv) / (64'(vref) - mv);
            return (r64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r64[31:0];
        endfunction

        function t_temp_result convert(logic [ttt_pkg::SAMPLE_W-1:0] sample);
            t_temp_result t;
            logic [63:0]  mv;
            logic [31:0]  r;
            logic [63:0]  prev;
            logic [63:0]  cur;
            int           lo;
            int           hi;
            int           mid;
            int           off;
            int           deg;
            int           tenths;
            off = int'(offset);
            t   = '0;
            if (full_scale == 0) begin
                t.status = ttt_pkg::ST_OPEN;
                t.res    = '1;
                return t;
            end
            mv = (64'(vref) * 64'(sample)) / 64'(full_scale);
            if (mv >= 64'(vref)) begin
                t.status = ttt_pkg::ST_OPEN;
                t.res    = '1;
                return t;
            end
            r = ohms_for(sample);
            t.res = r;
            // lower-bound bisection: first entry not above r
            lo = 0;
            hi = TS;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (32'(tbl[mid]) <= r) hi = mid;
                else lo = mid + 1;
            end
            if (lo >= TS) begin
                deg      = TS - 1 - off;
                t.status = ttt_pkg::ST_HOTTER;
                t.deg    = ttt_pkg::DEG_W'(deg);
                t.tenths = ttt_pkg::TEN_W'(deg * 10);
                t.idx    = ttt_pkg::EIDX_W'(TS - 1);
            end else if (lo == 0) begin
                deg      = -off;
                t.status = (32'(tbl[0]) == r) ? ttt_pkg::ST_OK : ttt_pkg::ST_COLDER;
                t.deg    = ttt_pkg::DEG_W'(deg);
                t.tenths = ttt_pkg::TEN_W'(deg * 10);
                t.idx    = '0;
            end else begin
                prev     = 64'(tbl[lo-1]);
                cur      = 64'(tbl[lo]);
                tenths   = (lo - 1 - off) * 10 +
                           int'((64'd10 * (prev - 64'(r))) / (prev - cur));
                t.status = ttt_pkg::ST_OK;
                t.deg    = ttt_pkg::DEG_W'(lo - off);
                t.tenths = ttt_pkg::TEN_W'(tenths);
                t.idx    = ttt_pkg::EIDX_W'(lo);
            end
            return t;
        endfunction

        function void note_input(logic req, logic [ttt_pkg::EIDX_W-1:0] eidx,
                                 logic [ttt_pkg::ENTRY_W-1:0] evalue,
                                 logic [ttt_pkg::SAMPLE_W-1:0] sample);
            if (req == ttt_pkg::REQ_LOAD) begin
                if (int'(eidx) < TS) tbl[eidx] = evalue;
            end else begin
                pending.push_back(convert(sample));
            end
        endfunction

        task report(string msg);
            $display("%0t ERROR: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_temp_result got);
            t_temp_result want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result status=%0d res=%0d", got.status, got.res));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.res !== want.res)
                report($sformatf("resistance got %0d want %0d", got.res, want.res));
            if (got.deg !== want.deg)
                report($sformatf("degrees got %0d want %0d", got.deg, want.deg));
            if (got.tenths !== want.tenths)
                report($sformatf("tenths got %0d want %0d", got.tenths, want.tenths));
            if (got.idx !== want.idx)
                report($sformatf("index got %0d want %0d", got.idx, want.idx));
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         cfg_we;
    logic [ttt_pkg::CFG_IW-1:0]   cfg_index;
    logic [ttt_pkg::CFG_W-1:0]    cfg_data;
    logic                         quiet;
    int                           stall_left = 0;
    thermistor_scoreboard         sb;

    ttt_in_if  in_if ();
    ttt_out_if out_if ();

    thermistor_table_temperature u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Mostly short gaps, a few long ones, none during quiet stretches
    function int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 60);
    endfunction

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result('{out_if.status, out_if.resistance_ohms, out_if.temp_degrees,
                              out_if.temp_tenths, out_if.found_index});
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_if.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 99) < 15) stall_left <= pick_gap();
        end
    end

    // Send one item and hold it until the transfer
    task send_item(logic req, logic [ttt_pkg::EIDX_W-1:0] eidx,
                   logic [ttt_pkg::ENTRY_W-1:0] evalue,
                   logic [ttt_pkg::SAMPLE_W-1:0] sample);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.req_type    <= req;
        in_if.entry_index <= eidx;
        in_if.entry_value <= evalue;
        in_if.adc_sample  <= sample;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(req, eidx, evalue, sample);
    endtask

    task load_entry(int eidx, logic [ttt_pkg::ENTRY_W-1:0] evalue);
        send_item(ttt_pkg::REQ_LOAD, ttt_pkg::EIDX_W'(eidx), evalue,
                  ttt_pkg::SAMPLE_W'($urandom));
    endtask

    task convert_sample(logic [ttt_pkg::SAMPLE_W-1:0] sample);
        send_item(ttt_pkg::REQ_CONVERT, ttt_pkg::EIDX_W'($urandom),
                  ttt_pkg::ENTRY_W'($urandom), sample);
    endtask

    // Hold input low until every reading is back and the block has settled
    task drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(logic [ttt_pkg::CFG_IW-1:0] index, int unsigned data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= ttt_pkg::CFG_W'(data);
        @(posedge i_clk);
        sb.set_reg(index, ttt_pkg::CFG_W'(data));
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task set_all(int unsigned series, int unsigned vref, int unsigned fs, int unsigned off);
        write_reg(ttt_pkg::CFG_SERIES, series);
        write_reg(ttt_pkg::CFG_REF, vref);
        write_reg(ttt_pkg::CFG_FS, fs);
        write_reg(ttt_pkg::CFG_OFF, off);
    endtask

    // Fill the whole table with a falling curve; a zero step leaves equal neighbors
    task fill_table(int unsigned start);
        int unsigned r;
        r = start;
        for (int i = 0; i < TS; i++) begin
            load_entry(i, ttt_pkg::ENTRY_W'(r));
            r = r - $urandom_range(0, r / 20);
        end
    endtask

    task random_items(int count);
        int roll;
        int unsigned fs;
        fs = sb.full_scale;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (n == count / 2 && $urandom_range(0, 1)) drain();
            if (roll < 10) begin
                load_entry($urandom_range(0, TS - 1), ttt_pkg::ENTRY_W'($urandom));
            end else if (roll < 18) begin
                load_entry($urandom_range(0, 255), ttt_pkg::ENTRY_W'($urandom));
            end else if (roll < 75) begin
                convert_sample(ttt_pkg::SAMPLE_W'($urandom_range(0, fs)));
            end else if (roll < 88) begin
                convert_sample(ttt_pkg::SAMPLE_W'(fs - $urandom_range(0, (fs < 8) ? fs : 8)));
            end else begin
                convert_sample(ttt_pkg::SAMPLE_W'($urandom));
            end
        end
    endtask

    // Stop a hung run
    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        sb                 = new();
        quiet              = 1'b0;
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        in_if.valid        <= 1'b0;
        in_if.req_type     <= ttt_pkg::REQ_LOAD;
        in_if.entry_index  <= '0;
        in_if.entry_value  <= '0;
        in_if.adc_sample   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults, falling table, each edge case
        fill_table(500000);
        convert_sample(16'd0);
        convert_sample(16'd4095);
        convert_sample(16'hFFFF);
        convert_sample(16'd1);
        convert_sample(16'd2048);
        load_entry(0, ttt_pkg::ENTRY_W'(sb.ohms_for(16'd3500)));
        convert_sample(16'd3500);
        convert_sample(16'd3600);
        load_entry(200, 20'hFFFFF);
        load_entry(255, 20'h00000);
        load_entry(TS, 20'h12345);
        load_entry(TS - 1, 20'h00000);
        convert_sample(16'd0);
        convert_sample(16'd1);
        load_entry(0, 20'hFFFFF);
        convert_sample(16'd4094);
        convert_sample(16'd4000);
        load_entry(TS - 1, 20'd1000);
        convert_sample(16'd3000);
        random_items(60);

        // Lowest settings
        drain();
        set_all(1, 1, 1, 0);
        random_items(40);

        // Highest settings
        drain();
        set_all(1000000, 5000, 65535, 255);
        random_items(50);

        // Back to defaults, no random gaps or stalls
        drain();
        quiet = 1'b1;
        set_all(ttt_pkg::SERIES_RST, ttt_pkg::REF_RST, ttt_pkg::FS_RST, ttt_pkg::OFF_RST);
        random_items(40);
        quiet = 1'b0;

        // Random settings
        for (int p = 0; p < 2; p++) begin
            drain();
            set_all($urandom_range(1, 1000000), $urandom_range(1, 5000),
                    $urandom_range(1, 65535), $urandom_range(0, 255));
            random_items(35);
        end

        drain();
        set_all(10000, 5000, 1023, 40);
        random_items(40);

        drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ thermistor_table_temperature.f @@
+incdir+sv
sv/ttt_pkg.sv
sv/ttt_in_if.sv
sv/ttt_out_if.sv
sv/ttt_ram.sv
sv/thermistor_table_temperature.sv
sv/ttt_checker.sv
tb/sv/thermistor_table_temperature_test.sv
